// ===== src/brp_pkg.sv =====
// Shared types and constants for the HTTP byte range parser.
// Used by brp_front, brp_queue, brp_back and http_byte_range_parser.
package brp_pkg;

  localparam int unsigned LengthBits  = 48;
  localparam int unsigned PartBits    = LengthBits + 1;
  localparam int unsigned ValueBits   = 64;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned PrefixLen   = 6;
  localparam int unsigned PosSat      = 7;

  localparam logic [7:0] CharComma = 8'h2c;
  localparam logic [7:0] CharDash  = 8'h2d;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharZero  = 8'h30;

  typedef enum logic [1:0] {
    VERDICT_NONE    = 2'd0,
    VERDICT_INVALID = 2'd1,
    VERDICT_UNSAT   = 2'd2,
    VERDICT_SAT     = 2'd3
  } brp_verdict_e;

  typedef struct packed {
    logic [7:0]            header_char;
    logic                  last;
    logic [LengthBits-1:0] entity_len;
    logic                  if_range_mismatch;
    logic                  no_header;
  } brp_in_t;

  typedef struct packed {
    brp_verdict_e          verdict;
    logic [LengthBits-1:0] range_start;
    logic [LengthBits-1:0] range_end;
    logic [PartBits-1:0]   part_length;
  } brp_out_t;

  typedef struct packed {
    logic ovf;
    logic bad;
    logic gap;
    logic content;
  } brp_flags_t;

  // One finished header as seen by the back end
  typedef struct packed {
    logic                  none;
    logic                  pre_bad;
    brp_flags_t            flags1;
    logic [ValueBits-1:0]  val1;
    brp_flags_t            flags2;
    logic [ValueBits-1:0]  val2;
    logic [LengthBits-1:0] cl;
  } brp_sum_t;

  // Lowercase unit prefix "bytes="
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h62;
      3'd1:    ch = 8'h79;
      3'd2:    ch = 8'h74;
      3'd3:    ch = 8'h65;
      3'd4:    ch = 8'h73;
      3'd5:    ch = 8'h3d;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== src/http_byte_range_parser.sv =====
// Top level of the HTTP Range header single byte range parser.
// Instantiates brp_front, brp_queue and brp_back; depends on brp_pkg.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_ready_o  | in_data_i  (brp_pkg::brp_in_t)
//   out     | output    | out_valid_o / out_ready_i| out_data_o (brp_pkg::brp_out_t)
//
// One header byte is taken per cycle while in_ready_o is high.
// The verdict passes from the queue through the judge stage and the part length stage
// into the output register, and out_valid_o rises when that register is loaded.
// Reset clears the token state, the queue pointers and both stage valids.
// in_ready_o drops only while the summary queue is full, i.e. when the output
// side has been stalled; per-byte work is the classify and times-ten accumulate.
module http_byte_range_parser #(
  parameter int unsigned QUEUE_DEPTH = brp_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  brp_pkg::brp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output brp_pkg::brp_out_t out_data_o
);

  logic              full;
  logic              push;
  brp_pkg::brp_sum_t push_data;
  logic              pop;
  logic              head_valid;
  brp_pkg::brp_sum_t head_data;

  brp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .sum_o      (push_data)
  );

  brp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_data_o  (head_data)
  );

  brp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_data_i  (head_data),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== src/brp_front.sv =====
// Front end: takes header bytes, tracks prefix, dash and comma, accumulates tokens.
// Emits one brp_pkg::brp_sum_t per header on its last byte. Depends on brp_pkg.
module brp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  brp_pkg::brp_in_t  in_data_i,
  input  logic              full_i,
  output logic              push_o,
  output brp_pkg::brp_sum_t sum_o
);

  logic [2:0]                      pos_q, pos_d;
  logic                            prefix_bad_q, prefix_bad_d;
  logic                            dash_q, dash_d;
  logic                            comma_q, comma_d;
  brp_pkg::brp_flags_t             f1_q, f1_d, f2_q, f2_d;
  logic [brp_pkg::ValueBits-1:0]   v1_q, v1_d, v2_q, v2_d;

  logic                            accept;
  logic                            take;
  logic [7:0]                      ch;
  logic [7:0]                      low;
  logic                            blank;
  logic                            digit;
  brp_pkg::brp_flags_t             tf_in, tf_out;
  logic [brp_pkg::ValueBits-1:0]   tv_in, tv_out;
  logic [brp_pkg::ValueBits+3:0]   acc;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign ch         = in_data_i.header_char;
  assign take       = !in_data_i.no_header &&
                      (!in_data_i.last || !in_data_i.if_range_mismatch);

  // Shared times-ten accumulator, applied to whichever token is open
  always_comb begin
    low   = (ch inside {[8'h41:8'h5a]}) ? (ch | 8'h20) : ch;
    blank = (ch == brp_pkg::CharSpace) || (ch == brp_pkg::CharTab);
    digit = ch inside {[8'h30:8'h39]};
    tf_in = dash_q ? f2_q : f1_q;
    tv_in = dash_q ? v2_q : v1_q;
    // the low nibble of an ASCII digit is its value
    acc   = ({4'b0, tv_in} << 3) + ({4'b0, tv_in} << 1)
            + {{(brp_pkg::ValueBits){1'b0}}, ch[3:0]};
    tf_out = tf_in;
    tv_out = tv_in;
    if (blank) begin
      if (tf_in.content) tf_out.gap = 1'b1;
    end else begin
      if (tf_in.gap) tf_out.bad = 1'b1;
      tf_out.content = 1'b1;
      if (digit) begin
        tv_out = acc[brp_pkg::ValueBits-1:0];
        if (|acc[brp_pkg::ValueBits+3:brp_pkg::ValueBits]) tf_out.ovf = 1'b1;
      end else begin
        tf_out.bad = 1'b1;
      end
    end
  end

  always_comb begin
    pos_d        = pos_q;
    prefix_bad_d = prefix_bad_q;
    dash_d       = dash_q;
    comma_d      = comma_q;
    f1_d         = f1_q;
    v1_d         = v1_q;
    f2_d         = f2_q;
    v2_d         = v2_q;
    if (pos_q < 3'(brp_pkg::PrefixLen)) begin
      if (low != brp_pkg::prefix_char(pos_q)) prefix_bad_d = 1'b1;
    end else if (ch == brp_pkg::CharComma) begin
      comma_d = 1'b1;
    end else if (ch == brp_pkg::CharDash && !dash_q) begin
      dash_d = 1'b1;
    end else if (!dash_q) begin
      f1_d = tf_out;
      v1_d = tv_out;
    end else begin
      f2_d = tf_out;
      v2_d = tv_out;
    end
    if (pos_q < 3'(brp_pkg::PosSat)) pos_d = pos_q + 3'd1;
  end

  always_comb begin
    sum_o.none    = in_data_i.no_header || in_data_i.if_range_mismatch;
    sum_o.pre_bad = prefix_bad_d || (pos_d < 3'(brp_pkg::PosSat)) || comma_d || !dash_d;
    sum_o.flags1  = f1_d;
    sum_o.val1    = v1_d;
    sum_o.flags2  = f2_d;
    sum_o.val2    = v2_d;
    sum_o.cl      = in_data_i.entity_len;
  end

  assign push_o = accept && in_data_i.last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      prefix_bad_q <= 1'b0;
      dash_q       <= 1'b0;
      comma_q      <= 1'b0;
      f1_q         <= '0;
      v1_q         <= '0;
      f2_q         <= '0;
      v2_q         <= '0;
    end else if (accept) begin
      if (in_data_i.last) begin
        // header done: start over for the next one
        pos_q        <= '0;
        prefix_bad_q <= 1'b0;
        dash_q       <= 1'b0;
        comma_q      <= 1'b0;
        f1_q         <= '0;
        v1_q         <= '0;
        f2_q         <= '0;
        v2_q         <= '0;
      end else if (take) begin
        pos_q        <= pos_d;
        prefix_bad_q <= prefix_bad_d;
        dash_q       <= dash_d;
        comma_q      <= comma_d;
        f1_q         <= f1_d;
        v1_q         <= v1_d;
        f2_q         <= f2_d;
        v2_q         <= v2_d;
      end
    end
  end

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (pos_q == 3'd0) && !dash_q && !comma_q && !prefix_bad_q)
    else $error("front state not cleared after last byte");

  a_pos_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(pos_q) == 3'(brp_pkg::PosSat)) |-> (pos_q == 3'(brp_pkg::PosSat)) || (pos_q == 3'd0))
    else $error("byte position left saturation other than by clearing");

endmodule

// ===== src/brp_queue.sv =====
// Short queue of finished header summaries between front and back end.
// Depends on brp_pkg for brp_sum_t.
module brp_queue #(
  parameter int unsigned DEPTH = brp_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  brp_pkg::brp_sum_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              head_valid_o,
  output brp_pkg::brp_sum_t head_data_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  brp_pkg::brp_sum_t mem_q [DEPTH];
  logic [PtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  assign full_o       = cnt_q == CntW'(DEPTH);
  assign head_valid_o = cnt_q != '0;
  assign head_data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    if (pop_i)  rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    if (push_i && !pop_i) cnt_d = cnt_q + CntW'(1);
    if (pop_i && !push_i) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("summary pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("pop from empty queue");

endmodule

// ===== src/brp_back.sv =====
// Back end: judges one header summary, then forms the part length.
// Two stall-able stages, the second is the output register. Depends on brp_pkg.
module brp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  brp_pkg::brp_sum_t head_data_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output brp_pkg::brp_out_t out_data_o
);

  localparam int unsigned LB = brp_pkg::LengthBits;
  localparam int unsigned VB = brp_pkg::ValueBits;

  logic                  s1_valid_q;
  brp_pkg::brp_verdict_e s1_verdict_q, s1_verdict_d;
  logic [LB-1:0]         s1_start_q, s1_start_d;
  logic [LB-1:0]         s1_end_q, s1_end_d;
  logic                  out_valid_q;
  brp_pkg::brp_out_t     out_q, out_d;
  logic                  out_adv, s1_adv;

  logic [VB-1:0]         cl_w;
  logic [LB-1:0]         cl_m1;
  logic                  good1, good2;

  assign out_adv = !out_valid_q || out_ready_i;
  assign s1_adv  = !s1_valid_q || out_adv;
  assign pop_o   = head_valid_i && s1_adv;

  // Judge: checks in fixed priority, start and end limited to the entity
  always_comb begin
    cl_w  = {{(VB - LB){1'b0}}, head_data_i.cl};
    cl_m1 = head_data_i.cl - LB'(1);
    good1 = head_data_i.flags1.content && !head_data_i.flags1.bad && !head_data_i.flags1.ovf;
    good2 = head_data_i.flags2.content && !head_data_i.flags2.bad && !head_data_i.flags2.ovf;
    s1_verdict_d = brp_pkg::VERDICT_SAT;
    s1_start_d   = '0;
    s1_end_d     = cl_m1;
    if (head_data_i.none) begin
      s1_verdict_d = brp_pkg::VERDICT_NONE;
    end else if (head_data_i.pre_bad) begin
      s1_verdict_d = brp_pkg::VERDICT_INVALID;
    end else if (!head_data_i.flags1.content && !head_data_i.flags2.content) begin
      s1_verdict_d = brp_pkg::VERDICT_INVALID;
    end else if (head_data_i.cl == '0) begin
      s1_verdict_d = brp_pkg::VERDICT_UNSAT;
    end else if (!head_data_i.flags1.content) begin
      // suffix form: last N bytes
      if (!good2 || head_data_i.val2 == '0) begin
        s1_verdict_d = brp_pkg::VERDICT_UNSAT;
      end else if (head_data_i.val2 < cl_w) begin
        s1_start_d = head_data_i.cl - head_data_i.val2[LB-1:0];
      end
    end else if (!good1) begin
      s1_verdict_d = brp_pkg::VERDICT_INVALID;
    end else if (head_data_i.val1 >= cl_w) begin
      s1_verdict_d = brp_pkg::VERDICT_UNSAT;
    end else begin
      s1_start_d = head_data_i.val1[LB-1:0];
      if (head_data_i.flags2.content) begin
        if (!good2) begin
          s1_verdict_d = brp_pkg::VERDICT_INVALID;
        end else if (head_data_i.val2 < head_data_i.val1) begin
          s1_verdict_d = brp_pkg::VERDICT_UNSAT;
        end else if (head_data_i.val2 < cl_w) begin
          s1_end_d = head_data_i.val2[LB-1:0];
        end
      end
    end
    if (s1_verdict_d != brp_pkg::VERDICT_SAT) begin
      s1_start_d = '0;
      s1_end_d   = '0;
    end
  end

  always_comb begin
    out_d.verdict     = s1_verdict_q;
    out_d.range_start = s1_start_q;
    out_d.range_end   = s1_end_q;
    out_d.part_length = '0;
    if (s1_verdict_q == brp_pkg::VERDICT_SAT) begin
      out_d.part_length = {1'b0, s1_end_q} - {1'b0, s1_start_q} + (LB + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv)  s1_valid_q  <= head_valid_i;
      if (out_adv) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_verdict_q <= s1_verdict_d;
      s1_start_q   <= s1_start_d;
      s1_end_q     <= s1_end_d;
    end
    if (out_adv && s1_valid_q) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_unsat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.verdict != brp_pkg::VERDICT_SAT) |->
      (out_data_o.range_start == '0) && (out_data_o.range_end == '0) &&
      (out_data_o.part_length == '0))
    else $error("range fields not zero on non-satisfiable verdict");

  a_sat_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.verdict == brp_pkg::VERDICT_SAT) |->
      (out_data_o.range_start <= out_data_o.range_end) && (out_data_o.part_length != '0))
    else $error("satisfiable range with start past end");

endmodule
